FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: hw/rtl/aef_pkg.sv
package aef_pkg;

  localparam int Y_W     = 24;
  localparam int W_W     = 17;
  localparam int G_W     = 24;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_I_W = 2;
  localparam int CFG_D_W = 24;

  localparam logic signed [Y_W-1:0] Y_MAX   = 24'sh7FFFFF;
  localparam logic signed [Y_W-1:0] Y_MIN   = 24'sh800000;
  localparam logic [W_W-1:0]        ONE_Q16 = 17'h10000;

  localparam logic [W_W-1:0] WMIN_RST = 17'd3277;
  localparam logic [W_W-1:0] WMAX_RST = 17'd36045;
  localparam logic [G_W-1:0] GAIN_RST = 24'd236223;

  localparam logic [CFG_I_W-1:0] CFG_WMIN = 2'd0;
  localparam logic [CFG_I_W-1:0] CFG_WMAX = 2'd1;
  localparam logic [CFG_I_W-1:0] CFG_GAIN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_FMUL,
    S_FUPD,
    S_SQ,
    S_GLO,
    S_GHI,
    S_WUPD,
    S_OUT
  } aef_state_t;

  typedef enum logic [1:0] {
    MS_FILT,
    MS_SQ,
    MS_GLO,
    MS_GHI
  } mul_sel_t;

  typedef struct packed {
    logic     idle;
    logic     take;
    logic     mul_en;
    mul_sel_t msel;
    logic     save_hi;
    logic     save_plo;
    logic     upd_y;
    logic     upd_w;
    logic     load_out;
  } aef_ctrl_t;

  function automatic logic [W_W-1:0] sat_one(input logic [W_W-1:0] w);
    return (w[W_W-1] && (|w[W_W-2:0])) ? ONE_Q16 : w;
  endfunction

endpackage

FILE: hw/rtl/aef_mul.sv
module aef_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [aef_pkg::MUL_W-1:0]     op_a,
  input  logic signed [aef_pkg::MUL_W-1:0]     op_b,
  output logic signed [aef_pkg::PROD_W-1:0]    prod
);
  import aef_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule

FILE: hw/rtl/aef_ctrl.sv
`include "assert_macros.svh"

module aef_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               first,
  input  logic               func,
  input  logic               out_free,
  output aef_pkg::aef_ctrl_t ctl
);
  import aef_pkg::*;

  aef_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.msel   = MS_FILT;
    unique case (state)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (accept) state_next = S_DIFF;
      end
      S_DIFF: begin
        ctl.take = 1'b1;
        if (first) state_next = S_OUT;
        else if (func) state_next = S_SQ;
        else state_next = S_FMUL;
      end
      S_FMUL: begin
        ctl.mul_en = 1'b1;
        ctl.msel   = MS_FILT;
        state_next = S_FUPD;
      end
      S_FUPD: begin
        ctl.upd_y  = 1'b1;
        state_next = S_OUT;
      end
      S_SQ: begin
        ctl.mul_en = 1'b1;
        ctl.msel   = MS_SQ;
        state_next = S_GLO;
      end
      S_GLO: begin
        ctl.mul_en  = 1'b1;
        ctl.msel    = MS_GLO;
        ctl.save_hi = 1'b1;
        state_next  = S_GHI;
      end
      S_GHI: begin
        ctl.mul_en   = 1'b1;
        ctl.msel     = MS_GHI;
        ctl.save_plo = 1'b1;
        state_next   = S_WUPD;
      end
      S_WUPD: begin
        ctl.upd_w  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLY(a_load_when_free, clk, rst, ctl.load_out, out_free, "output loaded while busy")
  `ASSERT_IMPLY(a_one_action, clk, rst, 1'b1, $onehot0({ctl.take, ctl.upd_y, ctl.upd_w, ctl.load_out}), "overlapping actions")
  `ASSERT_NEXT(a_upd_then_out, clk, rst, ctl.upd_y || ctl.upd_w, state == S_OUT, "update not followed by output")

endmodule

FILE: hw/rtl/adaptive_ema_filter.sv
// Adaptive exponential moving average.
// Input channel (in_valid/in_stall): func, sample, weight_in. func 0 filters
// with weight_in (Q1.16, clamped to 1.0); func 1 recomputes the stored weight
// from the squared error and the gain, clamped to weight_min..weight_max.
// The first word after reset is not filtered; it loads the scaled sample.
// Output channel (out_valid/out_stall): one result word per input word with
// filtered (Q.8), stored_weight (Q1.16) and ready_res.
// Config channel (cfg_valid/cfg_ready): cfg_index 0..2 selects weight_min,
// weight_max or weight_gain; other indexes are ignored. Write only when idle.
// Steps after accept: S_DIFF, then S_OUT for the first word; for func 0
// S_FMUL, S_FUPD, S_OUT; for func 1 S_SQ, S_GLO, S_GHI, S_WUPD, S_OUT. The
// next word is taken only after S_OUT loads the result into the output
// register. One 25x25 multiplier is shared by the filter product, the error
// square and the two partial products of the gain, stepped by the sequencer.
// A stalled result stays in the output register; the block finishes the next
// item and holds it until the register frees. Reset (synchronous) clears the
// filter state and restores the register defaults; in_stall is high in reset.
`include "assert_macros.svh"

module adaptive_ema_filter #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [aef_pkg::W_W-1:0]              weight_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [aef_pkg::Y_W-1:0]       filtered,
  output logic [aef_pkg::W_W-1:0]              stored_weight,
  output logic                                 ready_res,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [aef_pkg::CFG_I_W-1:0]          cfg_index,
  input  logic [aef_pkg::CFG_D_W-1:0]          cfg_data
);
  import aef_pkg::*;

  localparam int SW = SAMPLE_BITS + FRAC_BITS;
  localparam int XW = ((SW > Y_W) ? SW : Y_W) + 1;

  aef_ctrl_t ctl;
  logic      accept;
  logic      out_free;

  logic [W_W-1:0] weight_min, weight_max;
  logic [G_W-1:0] weight_gain;
  logic [W_W-1:0] wmin_s, wmax_s;

  logic signed [Y_W-1:0] x, smoothed;
  logic                  func_q, first_q, primed;
  logic [W_W-1:0]        a_q, adaptive_weight;
  logic signed [Y_W:0]   d;
  logic [G_W-1:0]        d2hi, plo;

  logic signed [XW-1:0]     sx;
  logic                     ovf;
  logic signed [Y_W-1:0]    x_sat;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod, prod_sh;
  logic [2*G_W:0]           wsum;
  logic [2*G_W-8:0]         inc;
  logic [W_W:0]             w_sum;
  logic [W_W-1:0]           w_new;
  logic                     out_valid_next;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = rst || !ctl.idle;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = !rst;

  assign wmin_s = sat_one(weight_min);
  assign wmax_s = sat_one(weight_max);

  // scale the sample and saturate to the filter range
  assign sx    = {{(XW-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample} <<< FRAC_BITS;
  assign ovf   = !((&sx[XW-1:Y_W-1]) || !(|sx[XW-1:Y_W-1]));
  assign x_sat = ovf ? (sx[XW-1] ? Y_MIN : Y_MAX) : sx[Y_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_min  <= WMIN_RST;
      weight_max  <= WMAX_RST;
      weight_gain <= GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WMIN: weight_min  <= cfg_data[W_W-1:0];
        CFG_WMAX: weight_max  <= cfg_data[W_W-1:0];
        CFG_GAIN: weight_gain <= cfg_data[G_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  aef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .first    (first_q),
    .func     (func_q),
    .out_free (out_free),
    .ctl      (ctl)
  );

  always_comb begin
    unique case (ctl.msel)
      MS_FILT: begin
        op_a = d;
        op_b = signed'({{(MUL_W-W_W){1'b0}}, a_q});
      end
      MS_SQ: begin
        op_a = d;
        op_b = d;
      end
      MS_GLO: begin
        op_a = signed'({1'b0, prod[G_W-1:0]});
        op_b = signed'({1'b0, weight_gain});
      end
      MS_GHI: begin
        op_a = signed'({1'b0, d2hi});
        op_b = signed'({1'b0, weight_gain});
      end
      default: begin
        op_a = d;
        op_b = d;
      end
    endcase
  end

  aef_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign prod_sh = prod >>> 16;

  // increment = (d2 * gain) >> 32, built from two 24-bit partial products
  assign wsum  = {1'b0, prod[2*G_W-1:0]} + {{(G_W+1){1'b0}}, plo};
  assign inc   = wsum[2*G_W:8];
  assign w_sum = {1'b0, wmin_s} + {1'b0, inc[W_W-1:0]};
  assign w_new = ((|inc[2*G_W-8:W_W]) || (w_sum > {1'b0, wmax_s})) ? wmax_s : w_sum[W_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      x       <= x_sat;
      func_q  <= func;
      first_q <= !primed;
      a_q     <= sat_one(weight_in);
    end
    if (ctl.take && !first_q) begin
      d <= {x[Y_W-1], x} - {smoothed[Y_W-1], smoothed};
    end
    if (ctl.save_hi) begin
      d2hi <= prod[2*G_W-1:G_W];
    end
    if (ctl.save_plo) begin
      plo <= prod[2*G_W-1:G_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed        <= '0;
      primed          <= 1'b0;
      adaptive_weight <= '0;
    end else begin
      if (ctl.take && first_q) begin
        smoothed        <= x;
        primed          <= 1'b1;
        adaptive_weight <= func_q ? wmin_s : '0;
      end
      if (ctl.upd_y) begin
        smoothed <= smoothed + signed'(prod_sh[Y_W-1:0]);
      end
      if (ctl.upd_w) begin
        adaptive_weight <= w_new;
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.load_out) out_valid_next = 1'b1;
    else if (!out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      filtered      <= smoothed;
      stored_weight <= adaptive_weight;
      ready_res     <= primed;
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall, "word taken while busy")
  `ASSERT_IMPLY(a_weight_range, clk, rst, out_valid, stored_weight <= ONE_Q16, "weight above one")
  `ASSERT_IMPLY(a_primed_out, clk, rst, out_valid, ready_res && primed, "result before priming")
  `ASSERT_NEXT(a_gain_steps, clk, rst, ctl.save_hi, ctl.save_plo, "gain partial products out of order")

endmodule
